>>> rtl/hesu_pkg.sv
// hesu_pkg: shared constants and types of the heading kalman update block
`default_nettype none
package hesu_pkg;

  // default internal saturation width
  localparam int HESU_DATA_WIDTH = 32;
  // width of every payload field but the one-bit row select and the one-bit zero-denominator flag
  localparam int HESU_FW = 32;
  // cordic rotation steps
  localparam int HESU_STEPS = 28;

  // angle constants, q4.28
  localparam logic signed [33:0] HESU_PI       = 34'sd843314857;
  localparam logic signed [33:0] HESU_NEG_PI   = -34'sd843314857;
  localparam logic signed [33:0] HESU_TWO_PI   = 34'sd1686629713;
  localparam logic signed [33:0] HESU_HALF_PI  = 34'sd421657428;
  localparam logic signed [33:0] HESU_NEG_HALF = -34'sd421657428;
  // cordic start vector, q2.30, carries the inverse gain
  localparam logic signed [33:0] HESU_GAIN     = 34'sd652032874;

  // arctangent of 2^-i, q4.28
  localparam logic [31:0] HESU_ATAN [HESU_STEPS] = '{
    32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
    32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
    32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
    32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  // input item as it travels through the front of the pipeline
  typedef struct packed {
    logic                      op;
    logic signed [HESU_FW-1:0] theta;
    logic        [HESU_FW-1:0] p;
    logic signed [HESU_FW-1:0] zm;
    logic signed [HESU_FW-1:0] vx;
    logic signed [HESU_FW-1:0] vy;
    logic        [HESU_FW-1:0] r;
  } hesu_front_t;

endpackage
`default_nettype wire

>>> rtl/hesu_if.sv
// hesu_in_if and hesu_out_if: valid/ready channels of the heading kalman update
`default_nettype none
interface hesu_in_if import hesu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [HESU_FW-1:0] theta_in;
  logic        [HESU_FW-1:0] var_in;
  logic signed [HESU_FW-1:0] e_dx;
  logic signed [HESU_FW-1:0] e_dy;
  logic signed [HESU_FW-1:0] v_dx;
  logic signed [HESU_FW-1:0] v_dy;
  logic        [HESU_FW-1:0] meas_var;

  modport source (output valid, op, theta_in, var_in, e_dx, e_dy, v_dx, v_dy, meas_var,
                  input ready);
  modport sink   (input valid, op, theta_in, var_in, e_dx, e_dy, v_dx, v_dy, meas_var,
                  output ready);
endinterface

interface hesu_out_if import hesu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [HESU_FW-1:0] theta_out;
  logic        [HESU_FW-1:0] var_out;
  logic                      div_zero;

  modport source (output valid, theta_out, var_out, div_zero, input ready);
  modport sink   (input valid, theta_out, var_out, div_zero, output ready);
endinterface
`default_nettype wire

>>> rtl/hesu_mul.sv
// hesu_mul: two-stage unsigned multiplier built from four half-width partial products
`default_nettype none
module hesu_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [AW-1:0]      a,
  input  wire logic [BW-1:0]      b,
  output logic      [AW+BW-1:0]   prod
);

  localparam int HA = (AW + 1) / 2;
  localparam int HB = (BW + 1) / 2;
  localparam int PW = AW + BW;

  logic [HA+HB-1:0]           ll;
  logic [HA+BW-HB-1:0]        lh;
  logic [AW-HA+HB-1:0]        hl;
  logic [AW-HA+BW-HB-1:0]     hh;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[HA-1:0] * b[HB-1:0];
      lh <= a[HA-1:0] * b[BW-1:HB];
      hl <= a[AW-1:HA] * b[HB-1:0];
      hh <= a[AW-1:HA] * b[BW-1:HB];
    end
  end

  // recombine
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(ll) + (PW'(lh) << HB) + (PW'(hl) << HA) + (PW'(hh) << (HA + HB));
    end
  end

endmodule
`default_nettype wire

>>> rtl/hesu_div.sv
// hesu_div: pipelined restoring divider, one quotient bit per stage, with side tag
`default_nettype none
module hesu_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output logic               out_valid,
  output logic      [NW-1:0] quo,
  output logic      [TW-1:0] tag_out
);

  logic [DW-1:0] rem  [NW];
  logic [NW-1:0] nq   [NW];
  logic [DW-1:0] dsor [NW];
  logic [TW-1:0] tag  [NW];
  logic          vld  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_src;
    logic [NW-1:0] nq_src;
    logic [DW-1:0] den_src;
    logic [TW-1:0] tag_src;
    logic          v_src;
    logic [DW-1:0] trial;

    if (i == 0) begin : g_first
      assign rem_src = '0;
      assign nq_src  = num;
      assign den_src = den;
      assign tag_src = tag_in;
      assign v_src   = in_valid;
    end else begin : g_rest
      assign rem_src = rem[i-1];
      assign nq_src  = nq[i-1];
      assign den_src = dsor[i-1];
      assign tag_src = tag[i-1];
      assign v_src   = vld[i-1];
    end

    // bring down the next dividend bit
    assign trial = {rem_src[DW-2:0], nq_src[NW-1]};

    // trial subtract, quotient bit shifts in at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= den_src) begin
          rem[i] <= trial - den_src;
          nq[i]  <= {nq_src[NW-2:0], 1'b1};
        end else begin
          rem[i] <= trial;
          nq[i]  <= {nq_src[NW-2:0], 1'b0};
        end
        dsor[i] <= den_src;
        tag[i]  <= tag_src;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_src;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = nq[NW-1];
  assign tag_out   = tag[NW-1];

endmodule
`default_nettype wire

>>> rtl/heading_ekf_scalar_update.sv
// heading_ekf_scalar_update: top level of the pipelined scalar heading kalman update
//
// One transfer on req carries one measurement update: the row select, the prior
// angle and variance, the gps and odometry displacements and the measurement
// variance. One transfer on rsp returns the posterior angle, the posterior
// variance and the zero-denominator flag, in the order the requests came in.
// A new request may be taken in every cycle; the sustained rate is one update
// per cycle while the skid register is empty. A request passes through angle
// reduction and cordic, products and saturation, the pipelined divider (one
// quotient bit per stage) and then gain products and the output register.
// When the receiver stalls, one further result is held in a skid register and
// req.ready drops only once that register is full; the pipeline then freezes
// as a whole and nothing is lost or repeated. Synchronous reset empties the
// pipeline, the output and skid registers; there is no other state.
`default_nettype none
module heading_ekf_scalar_update import hesu_pkg::*; #(
  parameter int DATA_WIDTH = HESU_DATA_WIDTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  hesu_in_if.sink    req,
  hesu_out_if.source rsp
);

  localparam int W  = DATA_WIDTH;
  localparam int QW = W + 16;
  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (W - 1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;
  localparam logic [2*W-1:0]      DCAP   = (2*W)'(1) << 34;

  typedef struct packed {
    logic signed [HESU_FW-1:0] theta;
    logic        [HESU_FW-1:0] p;
    logic        [HESU_FW-1:0] r;
    logic signed [W-1:0]       g;
    logic signed [W-1:0]       innov;
  } mid_t;

  localparam int TW = $bits(mid_t) + 2;

  // clamp to the signed internal width
  function automatic logic signed [W-1:0] sat_w(input logic signed [127:0] v);
    if (v > SAT_HI) return SAT_HI[W-1:0];
    if (v < SAT_LO) return SAT_LO[W-1:0];
    return v[W-1:0];
  endfunction

  // signed value from a magnitude, clamped to the signed internal width
  function automatic logic signed [W-1:0] mag_sat(input logic [127:0] m, input logic neg);
    logic [127:0] lim;
    logic [127:0] mm;
    lim = neg ? (128'd1 << (W - 1)) : (128'd1 << (W - 1)) - 128'd1;
    mm  = (m > lim) ? lim : m;
    return neg ? W'(-mm) : W'(mm);
  endfunction

  function automatic logic [W-1:0] absw(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  logic en;

  // ---------------- angle reduction ----------------
  logic               v0;
  hesu_front_t        f0;
  logic signed [33:0] z0;
  logic signed [33:0] th_ext;
  logic signed [33:0] zr1;

  assign th_ext = req.theta_in;

  // fold into minus pi .. pi
  always_comb begin
    if (th_ext > HESU_PI) begin
      zr1 = th_ext - HESU_TWO_PI;
    end else if (th_ext < HESU_NEG_PI) begin
      zr1 = th_ext + HESU_TWO_PI;
    end else begin
      zr1 = th_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0.op    <= req.op;
      f0.theta <= req.theta_in;
      f0.p     <= req.var_in;
      f0.zm    <= req.op ? req.e_dy : req.e_dx;
      f0.vx    <= req.v_dx;
      f0.vy    <= req.v_dy;
      f0.r     <= req.meas_var;
      z0       <= zr1;
    end
  end

  // ---------------- cordic ----------------
  logic signed [33:0] cx  [HESU_STEPS+1];
  logic signed [33:0] cy  [HESU_STEPS+1];
  logic signed [33:0] cz  [HESU_STEPS+1];
  logic               cfl [HESU_STEPS+1];
  logic               cv  [HESU_STEPS+1];
  hesu_front_t        cf  [HESU_STEPS+1];

  // fold into the right half plane, remember the sign flip
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= HESU_GAIN;
      cy[0] <= '0;
      cf[0] <= f0;
      if (z0 > HESU_HALF_PI) begin
        cz[0]  <= z0 - HESU_PI;
        cfl[0] <= 1'b1;
      end else if (z0 < HESU_NEG_HALF) begin
        cz[0]  <= z0 + HESU_PI;
        cfl[0] <= 1'b1;
      end else begin
        cz[0]  <= z0;
        cfl[0] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= v0;
    end
  end

  for (genvar i = 0; i < HESU_STEPS; i++) begin : g_cordic
    logic signed [33:0] ang;
    assign ang = $signed({2'b00, HESU_ATAN[i]});

    // one rotation step
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ang;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ang;
        end
        cfl[i+1] <= cfl[i];
        cf[i+1]  <= cf[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end
  end

  // ---------------- prediction and jacobian ----------------
  logic                      vt, vp, vj;
  hesu_front_t               ft, fp, fj;
  logic signed [HESU_FW-1:0] cos_t, sin_t;
  logic signed [63:0]        pcx, psx, pcy, psy;
  logic signed [W-1:0]       g_j, h_j;
  logic signed [63:0]        rcx, rsx, rcy, rsy;

  assign rcx = pcx >>> 30;
  assign rsx = psx >>> 30;
  assign rcy = pcy >>> 30;
  assign rsy = psy >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      // undo the half plane fold
      ft    <= cf[HESU_STEPS];
      cos_t <= cfl[HESU_STEPS] ? 32'(-cx[HESU_STEPS]) : 32'(cx[HESU_STEPS]);
      sin_t <= cfl[HESU_STEPS] ? 32'(-cy[HESU_STEPS]) : 32'(cy[HESU_STEPS]);
      // rotation products
      fp  <= ft;
      pcx <= cos_t * ft.vx;
      psx <= sin_t * ft.vx;
      pcy <= cos_t * ft.vy;
      psy <= sin_t * ft.vy;
      // selected row
      fj <= fp;
      if (fp.op) begin
        g_j <= sat_w(rcx - rsy);
        h_j <= sat_w(rsx + rcy);
      end else begin
        g_j <= sat_w(-rsx - rcy);
        h_j <= sat_w(rcx - rsy);
      end
    end
  end

  // ---------------- gp, gg and denominator ----------------
  logic                vb_unused_guard;
  logic                va, vb, vc, vd, ve, vf, vh;
  mid_t                ma, mb, mc, md, me, mf, mh;
  logic signed [W-1:0] gp_c, gp_d, gp_e, gp_f, gp_h;
  logic signed [W-1:0] gg_f;
  logic signed [W-1:0] d_h;
  logic signed [W-1:0] d_next;
  logic                dz_h;
  logic [W+31:0]       gp_prod;
  logic [2*W-1:0]      gg_prod;

  assign vb_unused_guard = 1'b0;
  assign d_next = sat_w(gg_f + $signed({1'b0, mf.r}));

  hesu_mul #(.AW(W), .BW(HESU_FW)) u_mul_gp (
    .clk  (clk),
    .en   (en),
    .a    (absw(g_j)),
    .b    (fj.p),
    .prod (gp_prod)
  );

  hesu_mul #(.AW(W), .BW(W)) u_mul_gg (
    .clk  (clk),
    .en   (en),
    .a    (absw(gp_c)),
    .b    (absw(mc.g)),
    .prod (gg_prod)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // innovation
      ma.theta <= fj.theta;
      ma.p     <= fj.p;
      ma.r     <= fj.r;
      ma.g     <= g_j;
      ma.innov <= sat_w(fj.zm - h_j);
      mb       <= ma;
      // gain numerator g*p
      mc   <= mb;
      gp_c <= mag_sat(128'(gp_prod >> 16), mb.g[W-1]);
      md   <= mc;
      gp_d <= gp_c;
      me   <= md;
      gp_e <= gp_d;
      // g*p*g
      mf   <= me;
      gp_f <= gp_e;
      gg_f <= mag_sat(128'(gg_prod >> 16), gp_e[W-1] ^ me.g[W-1]);
      // denominator
      mh   <= mf;
      gp_h <= gp_f;
      d_h  <= d_next;
      dz_h <= (d_next <= 0) | vb_unused_guard;
    end
  end

  // ---------------- gain division ----------------
  logic          qv;
  logic [QW-1:0] quo;
  logic [TW-1:0] qtag;
  mid_t          mq;
  logic          gpneg_q, dz_q;

  hesu_div #(.NW(QW), .DW(W), .TW(TW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vh),
    .num       ({absw(gp_h), 16'd0}),
    .den       ($unsigned(d_h)),
    .tag_in    ({mh, gp_h[W-1], dz_h}),
    .out_valid (qv),
    .quo       (quo),
    .tag_out   (qtag)
  );

  assign {mq, gpneg_q, dz_q} = qtag;

  // ---------------- posterior ----------------
  logic                vk, vl, vn, vu, vw, vq1, vq2, vr;
  mid_t                mk, ml, mn, mu, mw, mq1, mq2;
  logic signed [W-1:0] k_k, k_l, k_n;
  logic                dz_k, dz_l, dz_n, dz_u, dz_w, dz_q1, dz_q2;
  logic signed [W-1:0] kg_u, m_w, m_q1, m_q2;
  logic signed [35:0]  dth_u, dth_w, dth_q1, dth_q2;
  logic [2*W-1:0]      kg_prod, kt_prod;
  logic [W+31:0]       var_prod;
  logic [2*W-1:0]      kt_sh;
  logic [34:0]         dmag;
  logic [W+31:0]       vmag;
  logic signed [37:0]  th_sum;
  logic signed [HESU_FW-1:0] theta_r;
  logic        [HESU_FW-1:0] var_r;
  logic                      dz_r;

  hesu_mul #(.AW(W), .BW(W)) u_mul_kg (
    .clk  (clk),
    .en   (en),
    .a    (absw(k_k)),
    .b    (absw(mk.g)),
    .prod (kg_prod)
  );

  hesu_mul #(.AW(W), .BW(W)) u_mul_kt (
    .clk  (clk),
    .en   (en),
    .a    (absw(k_k)),
    .b    (absw(mk.innov)),
    .prod (kt_prod)
  );

  hesu_mul #(.AW(W), .BW(HESU_FW)) u_mul_var (
    .clk  (clk),
    .en   (en),
    .a    (absw(m_w)),
    .b    (mw.p),
    .prod (var_prod)
  );

  // angle step magnitude, capped well above the output range
  assign kt_sh = kt_prod >> 4;
  assign dmag  = (kt_sh > DCAP) ? DCAP[34:0] : kt_sh[34:0];
  assign vmag  = var_prod >> 16;
  assign th_sum = mq2.theta + dth_q2;

  always_ff @(posedge clk) begin
    if (en) begin
      // gain
      mk   <= mq;
      dz_k <= dz_q;
      k_k  <= mag_sat(128'(quo), gpneg_q);
      ml   <= mk;
      k_l  <= k_k;
      dz_l <= dz_k;
      mn   <= ml;
      k_n  <= k_l;
      dz_n <= dz_l;
      // k*g and k*innov
      mu   <= mn;
      dz_u <= dz_n;
      kg_u <= mag_sat(128'(kg_prod >> 16), k_n[W-1] ^ mn.g[W-1]);
      if (k_n[W-1] ^ mn.innov[W-1]) begin
        dth_u <= -$signed({1'b0, dmag});
      end else begin
        dth_u <= $signed({1'b0, dmag});
      end
      // 1 - k*g
      mw    <= mu;
      dz_w  <= dz_u;
      dth_w <= dth_u;
      m_w   <= sat_w(128'sd65536 - kg_u);
      mq1    <= mw;
      dz_q1  <= dz_w;
      dth_q1 <= dth_w;
      m_q1   <= m_w;
      mq2    <= mq1;
      dz_q2  <= dz_q1;
      dth_q2 <= dth_q1;
      m_q2   <= m_q1;
      // final clamp and pass-through
      dz_r <= dz_q2;
      if (dz_q2) begin
        theta_r <= mq2.theta;
        var_r   <= mq2.p;
      end else begin
        if (th_sum > 38'sd2147483647) begin
          theta_r <= 32'h7FFF_FFFF;
        end else if (th_sum < -38'sd2147483648) begin
          theta_r <= 32'h8000_0000;
        end else begin
          theta_r <= th_sum[31:0];
        end
        if (m_q2[W-1]) begin
          var_r <= '0;
        end else if (vmag > (W+32)'(32'hFFFF_FFFF)) begin
          var_r <= 32'hFFFF_FFFF;
        end else begin
          var_r <= vmag[31:0];
        end
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, vt, vp, vj, va, vb, vc, vd, ve, vf, vh} <= '0;
      {vk, vl, vn, vu, vw, vq1, vq2, vr} <= '0;
    end else if (en) begin
      v0  <= req.valid;
      vt  <= cv[HESU_STEPS];
      vp  <= vt;
      vj  <= vp;
      va  <= vj;
      vb  <= va;
      vc  <= vb;
      vd  <= vc;
      ve  <= vd;
      vf  <= ve;
      vh  <= vf;
      vk  <= qv;
      vl  <= vk;
      vn  <= vl;
      vu  <= vn;
      vw  <= vu;
      vq1 <= vw;
      vq2 <= vq1;
      vr  <= vq2;
    end
  end

  // ---------------- output register and skid ----------------
  logic                      out_valid, skid_valid;
  logic signed [HESU_FW-1:0] out_theta, skid_theta;
  logic        [HESU_FW-1:0] out_var, skid_var;
  logic                      out_dz, skid_dz;
  logic                      take;

  assign en   = ~skid_valid;
  assign take = en & vr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (~out_valid | rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (~out_valid | rsp.ready) begin
      if (skid_valid) begin
        out_theta <= skid_theta;
        out_var   <= skid_var;
        out_dz    <= skid_dz;
      end else begin
        out_theta <= theta_r;
        out_var   <= var_r;
        out_dz    <= dz_r;
      end
    end else if (take) begin
      skid_theta <= theta_r;
      skid_var   <= var_r;
      skid_dz    <= dz_r;
    end
  end

  assign req.ready     = en;
  assign rsp.valid     = out_valid;
  assign rsp.theta_out = out_theta;
  assign rsp.var_out   = out_var;
  assign rsp.div_zero  = out_dz;

`ifndef SYNTHESIS
  // skid only holds a result behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !rsp.ready))
    else $error("skid register filled without a stalled output");

  // a taken output drains the skid at once
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && rsp.ready |=> !skid_valid)
    else $error("skid register not drained after output transfer");
`endif

endmodule
`default_nettype wire
